// ===== sv/pcss_pkg.sv =====
// pcss_pkg: shared types and constants for the point cloud segment statistics block.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package pcss_pkg;

    localparam int RETURN_BINS_DEF = 5;
    localparam int COORD_WIDTH_DEF = 32;

    localparam int CNT_W      = 25;   // segment and histogram counters
    localparam int SEG_W      = 32;   // segment index
    localparam int VAL_W      = 32;   // result value
    localparam int WIDX_W     = 4;    // word index port
    localparam int OPQ_DEPTH  = 4;    // front-to-back op queue
    localparam int RESQ_DEPTH = 2;    // result queue
    localparam int APB_AW     = 2;
    localparam int APB_DW     = 32;

    localparam logic [CNT_W-1:0]  LIMIT_RESET = CNT_W'(20000000);
    localparam logic [APB_AW-1:0] ADDR_LIMIT  = 2'd0;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;
    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_SUM  = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] x_coord;
        logic signed [31:0] y_coord;
        logic signed [31:0] z_coord;
        logic [2:0]         return_number;
    } t_point;

    typedef struct packed {
        logic               kind;
        logic [31:0]        segment_index;
        logic [3:0]         word_index;
        logic signed [31:0] value;
        logic               bad_return;
        logic               last;
    } t_result;

    // Decoded control of one queued op.
    typedef struct packed {
        logic       flush;
        logic       bad;
        logic [2:0] bin;
    } t_op_ctl;

endpackage

// ===== sv/point_cloud_segment_stats.sv =====
// point_cloud_segment_stats: top level; config register, front end, back end, result queue.
// Depends on pcss_pkg, pcss_front, pcss_back, pcss_resq.
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Beat
// --------  ---  -----------------  -----------------------------------------
// point     in   push / full        t_point: cmd, x/y/z, return number
// result    out  empty / pop        t_result: kind, segment, word, value, flags
// config    in   APB psel/penable   segment_limit at byte address 0
//
// One point beat per clock: count, histogram and bounds update in the same back-end
// cycle in which the acknowledgement lands in the result queue. A segment close
// emits 7 + RETURN_BINS summary beats (12 at the default) before the waiting point
// is taken; the 4-deep op queue absorbs input meanwhile and full rises when it
// fills. A stalled result side backs up through the 2-deep result queue.
// Reset is synchronous; there is no clearing pass.

module point_cloud_segment_stats #(
    parameter int COORD_WIDTH = pcss_pkg::COORD_WIDTH_DEF,
    parameter int RETURN_BINS = pcss_pkg::RETURN_BINS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // point channel
    input  logic                          push,
    output logic                          full,
    input  pcss_pkg::t_point              i_point,
    // result channel
    output logic                          empty,
    input  logic                          pop,
    output pcss_pkg::t_result             o_result,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pcss_pkg::APB_AW-1:0]   paddr,
    input  logic [pcss_pkg::APB_DW-1:0]   pwdata,
    output logic [pcss_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    logic [pcss_pkg::CNT_W-1:0]      r_limit;

    logic                            w_op_valid, w_op_pop;
    pcss_pkg::t_op_ctl               w_op_ctl;
    logic [2:0][COORD_WIDTH-1:0]     w_op_coord;
    logic                            w_res_wr, w_res_ready;
    pcss_pkg::t_result               w_res;

    // ---- configuration: single register, zero-wait access
    assign pready = 1'b1;
    assign prdata = (paddr == pcss_pkg::ADDR_LIMIT) ? pcss_pkg::APB_DW'(r_limit) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= pcss_pkg::LIMIT_RESET;
        end else if (psel && penable && pwrite && pready && (paddr == pcss_pkg::ADDR_LIMIT)) begin
            r_limit <= pwdata[pcss_pkg::CNT_W-1:0];
        end
    end

    // ---- front end: accept and decode
    pcss_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .RETURN_BINS (RETURN_BINS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_point    (i_point),
        .o_op_valid (w_op_valid),
        .o_op_ctl   (w_op_ctl),
        .o_op_coord (w_op_coord),
        .i_op_pop   (w_op_pop)
    );

    // ---- back end: segment state and summary sequencing
    pcss_back #(
        .COORD_WIDTH (COORD_WIDTH),
        .RETURN_BINS (RETURN_BINS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_limit     (r_limit),
        .i_op_valid  (w_op_valid),
        .i_op_ctl    (w_op_ctl),
        .i_op_coord  (w_op_coord),
        .o_op_pop    (w_op_pop),
        .i_res_ready (w_res_ready),
        .o_res_wr    (w_res_wr),
        .o_res       (w_res)
    );

    // ---- result queue feeding the output port
    pcss_resq u_resq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (w_res_wr),
        .i_data   (w_res),
        .o_can_wr (w_res_ready),
        .o_empty  (empty),
        .i_pop    (pop),
        .o_data   (o_result)
    );

endmodule

// ===== sv/pcss_front.sv =====
// pcss_front: accepts input beats, decodes them and holds them in a short op queue.
// Depends on pcss_pkg.
`timescale 1ns / 1ps

module pcss_front #(
    parameter int COORD_WIDTH = pcss_pkg::COORD_WIDTH_DEF,
    parameter int RETURN_BINS = pcss_pkg::RETURN_BINS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    output logic                              o_full,
    input  pcss_pkg::t_point                  i_point,
    output logic                              o_op_valid,
    output pcss_pkg::t_op_ctl                 o_op_ctl,
    output logic [2:0][COORD_WIDTH-1:0]       o_op_coord,
    input  logic                              i_op_pop
);

    localparam int PW = $clog2(pcss_pkg::OPQ_DEPTH);

    pcss_pkg::t_op_ctl             r_ctl [pcss_pkg::OPQ_DEPTH];
    logic [2:0][COORD_WIDTH-1:0]   r_crd [pcss_pkg::OPQ_DEPTH];
    logic [PW-1:0]                 r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]                 r_rd_ptr, n_rd_ptr;
    logic [PW:0]                   r_cnt, n_cnt;

    pcss_pkg::t_op_ctl             w_ctl;
    logic [2:0][COORD_WIDTH-1:0]   w_crd;
    logic                          w_wr, w_rd;

    // decode: return number 0 or above the bin count is flagged
    always_comb begin
        w_ctl.flush = (i_point.cmd == pcss_pkg::CMD_FLUSH);
        w_ctl.bad   = (i_point.return_number == 3'd0) ||
                      (int'(i_point.return_number) > RETURN_BINS);
        w_ctl.bin   = i_point.return_number - 3'd1;
        w_crd[0]    = COORD_WIDTH'(i_point.x_coord);
        w_crd[1]    = COORD_WIDTH'(i_point.y_coord);
        w_crd[2]    = COORD_WIDTH'(i_point.z_coord);
    end

    assign o_full     = (r_cnt == (PW+1)'(pcss_pkg::OPQ_DEPTH));
    assign o_op_valid = (r_cnt != '0);
    assign o_op_ctl   = r_ctl[r_rd_ptr];
    assign o_op_coord = r_crd[r_rd_ptr];

    assign w_wr = i_push & ~o_full;
    assign w_rd = i_op_pop & o_op_valid;

    always_comb begin
        n_wr_ptr = w_wr ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = w_rd ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_cnt    = r_cnt + (PW+1)'(w_wr) - (PW+1)'(w_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_ctl[r_wr_ptr] <= w_ctl;
            r_crd[r_wr_ptr] <= w_crd;
        end
    end

endmodule

// ===== sv/pcss_back.sv =====
// pcss_back: segment state (count, histogram, bounds, index) and the summary sequencer.
// Depends on pcss_pkg.
`timescale 1ns / 1ps

module pcss_back #(
    parameter int COORD_WIDTH = pcss_pkg::COORD_WIDTH_DEF,
    parameter int RETURN_BINS = pcss_pkg::RETURN_BINS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [pcss_pkg::CNT_W-1:0]        i_limit,
    input  logic                              i_op_valid,
    input  pcss_pkg::t_op_ctl                 i_op_ctl,
    input  logic [2:0][COORD_WIDTH-1:0]       i_op_coord,
    output logic                              o_op_pop,
    input  logic                              i_res_ready,
    output logic                              o_res_wr,
    output pcss_pkg::t_result                 o_res
);

    localparam int SUMW = 7 + RETURN_BINS;        // words in one summary
    localparam int WW   = $clog2(SUMW);
    localparam logic signed [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic [pcss_pkg::CNT_W-1:0]       r_count, n_count;
    logic [pcss_pkg::CNT_W-1:0]       r_hist [RETURN_BINS];
    logic [pcss_pkg::CNT_W-1:0]       n_hist [RETURN_BINS];
    logic signed [COORD_WIDTH-1:0]    r_min [3];
    logic signed [COORD_WIDTH-1:0]    n_min [3];
    logic signed [COORD_WIDTH-1:0]    r_max [3];
    logic signed [COORD_WIDTH-1:0]    n_max [3];
    logic                             r_open, n_open;
    logic [pcss_pkg::SEG_W-1:0]       r_seg, n_seg;
    logic [WW-1:0]                    r_widx, n_widx;

    logic                             w_go, w_close, w_last_word;
    logic signed [pcss_pkg::VAL_W-1:0] w_sum_val;
    logic signed [COORD_WIDTH-1:0]    w_c;

    assign w_go        = i_op_valid & i_res_ready;
    assign w_close     = r_open & (i_op_ctl.flush | (r_count >= i_limit));
    assign w_last_word = (r_widx == WW'(SUMW - 1));

    // summary word picked by the word counter
    always_comb begin
        w_sum_val = signed'(pcss_pkg::VAL_W'(r_count));
        for (int k = 0; k < 3; k++) begin
            if (r_widx == WW'(k))     w_sum_val = pcss_pkg::VAL_W'(r_min[k]);
            if (r_widx == WW'(3 + k)) w_sum_val = pcss_pkg::VAL_W'(r_max[k]);
        end
        for (int b = 0; b < RETURN_BINS; b++) begin
            if (r_widx == WW'(6 + b)) w_sum_val = signed'(pcss_pkg::VAL_W'(r_hist[b]));
        end
    end

    always_comb begin
        n_count = r_count;
        n_hist  = r_hist;
        n_min   = r_min;
        n_max   = r_max;
        n_open  = r_open;
        n_seg   = r_seg;
        n_widx  = r_widx;
        w_c     = '0;

        o_op_pop = 1'b0;
        o_res_wr = 1'b0;
        o_res    = '0;

        if (w_go) begin
            priority if (w_close) begin
                // one summary word per cycle while the result queue has room; the point waits until it is done
                o_res_wr            = 1'b1;
                o_res.kind          = pcss_pkg::KIND_SUM;
                o_res.segment_index = r_seg;
                o_res.word_index    = 4'(r_widx);
                o_res.value         = w_sum_val;
                if (w_last_word) begin
                    n_widx  = '0;
                    n_count = '0;
                    for (int b = 0; b < RETURN_BINS; b++) n_hist[b] = '0;
                    n_open     = 1'b0;
                    o_res.last = i_op_ctl.flush;
                    o_op_pop   = i_op_ctl.flush;
                end else begin
                    n_widx = r_widx + 1'b1;
                end
            end else if (i_op_ctl.flush) begin
                // flush with no open segment: dropped silently
                o_op_pop = 1'b1;
            end else begin
                o_op_pop = 1'b1;
                o_res_wr = 1'b1;
                if (!r_open) begin
                    n_seg  = r_seg + 1'b1;
                    n_open = 1'b1;
                end
                n_count = r_count + 1'b1;
                for (int b = 0; b < RETURN_BINS; b++) begin
                    if (!i_op_ctl.bad && (int'(i_op_ctl.bin) == b)) n_hist[b] = r_hist[b] + 1'b1;
                end
                for (int k = 0; k < 3; k++) begin
                    w_c = signed'(i_op_coord[k]);
                    if (w_c < r_min[k]) n_min[k] = w_c;
                    if (w_c > r_max[k]) n_max[k] = w_c;
                end
                o_res.kind          = pcss_pkg::KIND_ACK;
                o_res.segment_index = n_seg;
                o_res.word_index    = '0;
                o_res.value         = signed'(pcss_pkg::VAL_W'(n_count));
                o_res.bad_return    = i_op_ctl.bad;
                o_res.last          = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            for (int b = 0; b < RETURN_BINS; b++) r_hist[b] <= '0;
            for (int k = 0; k < 3; k++) begin
                r_min[k] <= CMAX;
                r_max[k] <= CMIN;
            end
            r_open <= 1'b1;
            r_seg  <= pcss_pkg::SEG_W'(1);
            r_widx <= '0;
        end else begin
            r_count <= n_count;
            r_hist  <= n_hist;
            r_min   <= n_min;
            r_max   <= n_max;
            r_open  <= n_open;
            r_seg   <= n_seg;
            r_widx  <= n_widx;
        end
    end

endmodule

// ===== sv/pcss_resq.sv =====
// pcss_resq: two-entry result queue between the back end and the result port.
// Depends on pcss_pkg.
`timescale 1ns / 1ps

module pcss_resq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr,
    input  pcss_pkg::t_result  i_data,
    output logic               o_can_wr,
    output logic               o_empty,
    input  logic               i_pop,
    output pcss_pkg::t_result  o_data
);

    localparam int PW = $clog2(pcss_pkg::RESQ_DEPTH);

    pcss_pkg::t_result r_mem [pcss_pkg::RESQ_DEPTH];
    logic [PW-1:0]     r_wr_ptr, r_rd_ptr;
    logic [PW:0]       r_cnt, n_cnt;
    logic              w_wr, w_rd;

    // room is judged on the registered count only, so pop never reaches the back end
    assign o_can_wr = (r_cnt != (PW+1)'(pcss_pkg::RESQ_DEPTH));
    assign o_empty  = (r_cnt == '0);
    assign o_data   = r_mem[r_rd_ptr];

    assign w_wr  = i_wr & o_can_wr;
    assign w_rd  = i_pop & ~o_empty;
    assign n_cnt = r_cnt + (PW+1)'(w_wr) - (PW+1)'(w_rd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_wr) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (w_rd) r_rd_ptr <= r_rd_ptr + 1'b1;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== tb/pcss_checker.sv =====
// pcss_checker: watches the point, result and config channels of point_cloud_segment_stats,
// predicts every result beat and compares it with what the block returns.
// Depends on pcss_pkg.
`timescale 1ns / 1ps

module pcss_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic                          i_full,
    input  pcss_pkg::t_point              i_point,
    input  logic                          i_empty,
    input  logic                          i_pop,
    input  pcss_pkg::t_result             i_result,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [pcss_pkg::APB_AW-1:0]   i_paddr,
    input  logic [pcss_pkg::APB_DW-1:0]   i_pwdata,
    input  logic                          i_pready,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_checked
);
    import pcss_pkg::*;

    localparam int         BINS        = RETURN_BINS_DEF;
    localparam logic [3:0] WORD_MIN_X  = 4'd0;
    localparam logic [3:0] WORD_MAX_X  = 4'd3;
    localparam logic [3:0] WORD_HIST_1 = 4'd6;
    localparam logic [3:0] WORD_COUNT  = 4'(6 + BINS);

    // segment statistics as the block should hold them
    logic [CNT_W-1:0]   limit_reg;
    logic [CNT_W-1:0]   seg_count;
    logic [CNT_W-1:0]   hist [BINS];
    logic signed [31:0] lo_bound [3];
    logic signed [31:0] hi_bound [3];
    logic               seg_open;
    logic [31:0]        seg_index;

    t_result results_due[$];
    int      fail_count;
    int      checked;
    int      pending_n;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_n;
    assign o_checked    = checked;

    initial begin
        fail_count = 0;
        checked    = 0;
        pending_n  = 0;
    end

    // append one expected beat at the tail
    task automatic queue_result(input t_result r);
        results_due = {results_due, r};
    endtask

    task automatic clear_stats();
        limit_reg = LIMIT_RESET;
        seg_count = '0;
        for (int i = 0; i < BINS; i++) hist[i] = '0;
        for (int i = 0; i < 3; i++) begin
            lo_bound[i] = 32'sh7fff_ffff;
            hi_bound[i] = 32'sh8000_0000;
        end
        seg_open  = 1'b1;
        seg_index = 32'd1;
    endtask

    // twelve summary words of the open segment, then count and histogram clear
    task automatic close_segment();
        t_result r;
        r               = '0;
        r.kind          = KIND_SUM;
        r.segment_index = seg_index;
        for (int i = 0; i < 3; i++) begin
            r.word_index = WORD_MIN_X + 4'(i);
            r.value      = lo_bound[i];
            queue_result(r);
        end
        for (int i = 0; i < 3; i++) begin
            r.word_index = WORD_MAX_X + 4'(i);
            r.value      = hi_bound[i];
            queue_result(r);
        end
        for (int i = 0; i < BINS; i++) begin
            r.word_index = WORD_HIST_1 + 4'(i);
            r.value      = {7'd0, hist[i]};
            queue_result(r);
        end
        r.word_index = WORD_COUNT;
        r.value      = {7'd0, seg_count};
        queue_result(r);
        seg_count = '0;
        for (int i = 0; i < BINS; i++) hist[i] = '0;
        seg_open = 1'b0;
    endtask

    task automatic account_beat(input t_point p);
        int                 n_prior;
        logic               bad;
        logic signed [31:0] c [3];
        t_result            r;
        n_prior = results_due.size();
        if (p.cmd == CMD_FLUSH) begin
            if (seg_open) close_segment();
        end else begin
            if (!seg_open || seg_count >= limit_reg) begin
                if (seg_open) close_segment();
                seg_index = seg_index + 32'd1;
                seg_open  = 1'b1;
            end
            c[0] = $signed(p.x_coord);
            c[1] = $signed(p.y_coord);
            c[2] = $signed(p.z_coord);
            bad  = (p.return_number == 3'd0) || (int'(p.return_number) > BINS);
            seg_count = seg_count + 1'b1;
            if (!bad) hist[int'(p.return_number) - 1] = hist[int'(p.return_number) - 1] + 1'b1;
            for (int i = 0; i < 3; i++) begin
                if (c[i] < lo_bound[i]) lo_bound[i] = c[i];
                if (c[i] > hi_bound[i]) hi_bound[i] = c[i];
            end
            r               = '0;
            r.kind          = KIND_ACK;
            r.segment_index = seg_index;
            r.value         = {7'd0, seg_count};
            r.bad_return    = bad;
            queue_result(r);
        end
        // flag the final beat this input caused
        if (results_due.size() > n_prior) begin
            r      = results_due[results_due.size() - 1];
            r.last = 1'b1;
            results_due[results_due.size() - 1] = r;
        end
    endtask

    task automatic check_beat(input t_result got);
        t_result want;
        if (results_due.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("unexpected result beat: kind %0d seg %0d word %0d value %0d",
                         got.kind, got.segment_index, got.word_index, got.value);
            return;
        end
        want = results_due.pop_front();
        checked++;
        if (got.kind !== want.kind || got.segment_index !== want.segment_index ||
            got.word_index !== want.word_index || got.value !== want.value ||
            got.bad_return !== want.bad_return || got.last !== want.last) begin
            fail_count++;
            if (fail_count <= 10) begin
                $display("result mismatch at beat %0d", checked);
                $display("  expected kind %0d seg %0d word %0d value %0d bad %0d last %0d",
                         want.kind, want.segment_index, want.word_index, want.value,
                         want.bad_return, want.last);
                $display("  actual   kind %0d seg %0d word %0d value %0d bad %0d last %0d",
                         got.kind, got.segment_index, got.word_index, got.value,
                         got.bad_return, got.last);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_stats();
            results_due.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == ADDR_LIMIT)
                limit_reg = i_pwdata[CNT_W-1:0];
            if (i_push && !i_full) account_beat(i_point);
            if (i_pop && !i_empty) check_beat(i_result);
        end
        pending_n = results_due.size();
    end

endmodule

// ===== tb/tb_top.sv =====
// tb_top: stimulus and verdict for point_cloud_segment_stats.
// Drives points, flushes and segment_limit writes; pcss_checker does all prediction.
// Depends on pcss_pkg, point_cloud_segment_stats, pcss_checker.
`timescale 1ns / 1ps

module tb_top;
    import pcss_pkg::*;

    // Drain after the last expected beat: a trailing flush on a closed segment
    // yields no beat but may still sit in the 4-deep op queue.
    localparam int DRAIN_CYCLES = 32;
    // Cycles with no beat moving on either channel before we give up.
    // Worst honest gap is a send gap plus a pop stall plus a summary burst, or a
    // config pause; this is far above both.
    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_BEATS  = 32;
    localparam int N_PHASES     = 6;

    logic                i_clk;
    logic                i_rst_n;
    logic                push;
    logic                full;
    t_point              i_point;
    logic                empty;
    logic                pop;
    t_result             o_result;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    int fail_count;
    int pending;
    int checked;

    bit allow_idle;
    int pop_hold;
    int idle_run;
    int n_points;
    int n_flushes;
    int n_limits;

    logic [31:0] phase_limit [N_PHASES];

    point_cloud_segment_stats u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_point  (i_point),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    pcss_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_point      (i_point),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_result     (o_result),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #5 i_clk = ~i_clk;

    // Result side: pop held high except for random stall bursts.
    // Decided once per falling edge so pop never toggles twice in one step.
    always @(negedge i_clk) begin
        if (pop_hold > 0) begin
            pop = 1'b0;
            pop_hold--;
        end else if (allow_idle && $urandom_range(0, 5) == 0) begin
            pop      = 1'b0;
            pop_hold = $urandom_range(0, 8);
        end else begin
            pop = 1'b1;
        end
    end

    // Watchdog: any accepted beat on either side restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            idle_run = 0;
        end else begin
            idle_run++;
            if (idle_run >= STALL_LIMIT) begin
                $display("watchdog: no beat moved for %0d cycles, %0d results outstanding",
                         STALL_LIMIT, pending);
                $display("status: fail");
                $finish;
            end
        end
    end

    function automatic t_point make_point(input logic [31:0] x, input logic [31:0] y,
                                          input logic [31:0] z, input logic [2:0] rn);
        t_point p;
        p.cmd           = CMD_ADD;
        p.x_coord       = x;
        p.y_coord       = y;
        p.z_coord       = z;
        p.return_number = rn;
        return p;
    endfunction

    // coordinates and return number of a flush are don't-care; randomize them
    function automatic t_point make_flush();
        t_point p;
        p     = make_point($urandom, $urandom, $urandom, 3'($urandom_range(0, 7)));
        p.cmd = CMD_FLUSH;
        return p;
    endfunction

    // mix of full-range values, both extremes and a cluster around zero
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'($urandom_range(0, 200)) - 32'd100;
            default: return $urandom;
        endcase
    endfunction

    // mostly valid returns, with 0, 6 and 7 showing up now and then
    function automatic logic [2:0] rand_return();
        if ($urandom_range(0, 4) == 0) return 3'($urandom_range(0, 7));
        return 3'($urandom_range(1, RETURN_BINS_DEF));
    endfunction

    task automatic send(input t_point p);
        @(negedge i_clk);
        if (allow_idle && $urandom_range(0, 4) == 0) begin
            push = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        i_point = p;
        push    = 1'b1;
        do @(posedge i_clk); while (full);
        if (p.cmd == CMD_FLUSH) n_flushes++;
        else n_points++;
    endtask

    // wait until every expected beat is back and the op queue has emptied
    task automatic settle();
        @(negedge i_clk);
        push = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [31:0] v);
        @(negedge i_clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = ADDR_LIMIT;
        pwdata  = v;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        n_limits++;
    endtask

    initial begin
        i_clk      = 1'b0;
        i_rst_n    = 1'b0;
        push       = 1'b0;
        i_point    = '0;
        pop        = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        allow_idle = 1'b1;
        pop_hold   = 0;
        idle_run   = 0;
        n_points   = 0;
        n_flushes  = 0;
        n_limits   = 0;

        // one limit per random phase: single point, zero, the widest value,
        // small ones, and one with junk in the unused upper data bits
        phase_limit[0] = 32'd1;
        phase_limit[1] = 32'd0;
        phase_limit[2] = 32'h01ff_ffff;
        phase_limit[3] = 32'd3;
        phase_limit[4] = ($urandom & 32'hfe00_0000) | 32'($urandom_range(2, 9));
        phase_limit[5] = 32'd6;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part at the reset limit.
        // Flush before any point: summary carries the untouched bound extremes.
        send(make_flush());
        // Flush with no open segment: no beat at all.
        send(make_flush());
        // Point on a closed segment opens segment 2 without a summary.
        send(make_point(32'd0, 32'd0, 32'd0, 3'd1));
        // Every return number, valid and not, with coordinate extremes.
        send(make_point(32'h8000_0000, 32'h7fff_ffff, 32'd0, 3'd0));
        send(make_point(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 3'd1));
        send(make_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 3'd2));
        send(make_point(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 3'd3));
        send(make_point($urandom, $urandom, $urandom, 3'd4));
        send(make_point($urandom, $urandom, $urandom, 3'd5));
        send(make_point($urandom, $urandom, $urandom, 3'd6));
        send(make_point($urandom, $urandom, $urandom, 3'd7));
        send(make_flush());
        // Fresh segment after a flush, starting with a bad return.
        send(make_point(32'hffff_ffff, 32'd1, 32'h8000_0000, 3'd7));
        send(make_point(32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0001, 3'd5));
        send(make_flush());

        // Random phases, one segment limit each; the last runs without idling.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            settle();
            write_limit(phase_limit[ph]);
            if (ph == N_PHASES - 1) allow_idle = 1'b0;
            for (int k = 0; k < PHASE_BEATS; k++) begin
                if ($urandom_range(0, 9) == 0)
                    send(make_flush());
                else
                    send(make_point(rand_coord(), rand_coord(), rand_coord(), rand_return()));
            end
        end

        @(negedge i_clk);
        push = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("covered %0d points and %0d flushes across %0d segment limit settings",
                 n_points, n_flushes, n_limits);
        $display("compared %0d result beats, %0d failures", checked, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== point_cloud_segment_stats.f =====
sv/pcss_pkg.sv
sv/pcss_front.sv
sv/pcss_back.sv
sv/pcss_resq.sv
sv/point_cloud_segment_stats.sv
tb/pcss_checker.sv
tb/tb_top.sv
